// ----- design/bsti_pkg.sv -----
// Shared types, codes and sizes for the array-backed search tree engine.
`timescale 1ns / 1ps

package bsti_pkg;

    // Default node store size
    localparam int CAPACITY_DEF = 32;

    // Field widths
    localparam int VALUE_W = 32;
    localparam int OP_W    = 2;
    localparam int KIND_W  = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_IN     = 2'd1;
    localparam logic [OP_W-1:0] OP_PRE    = 2'd2;
    localparam logic [OP_W-1:0] OP_POST   = 2'd3;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_INSERTED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FULL     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ELEMENT  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_EMPTY    = 2'd3;

    // One result transaction
    typedef struct packed {
        logic               last;
        logic [VALUE_W-1:0] value;
        logic [KIND_W-1:0]  kind;
    } result_t;

endpackage

// ----- design/bst_insert_traverse_engine_core.sv -----
// Top level of the array-backed binary search tree insert and walk engine.
`timescale 1ns / 1ps

// Keeps up to CAPACITY signed 32-bit keys as a binary search tree in a node
// memory of {key, left link, right link} entries, one transaction at a time.
// An insert (tuser 0) descends from the root one level per clock, reading one
// node a cycle from the node memory, with keys equal to a node going left, and
// answers "inserted" once the new node is written; on a full tree it answers
// "full" without any node access. A walk (tuser 1 in-order, 2 pre-order,
// 3 post-order) emits every key with tlast on the final one, or one "empty"
// result on an empty tree. Walks keep their pending nodes on a stack memory,
// and their pace is set by the registered reads of the node and stack
// memories and by the single stack write port. Results leave through an
// output register, so a stalled m_tready only pauses the engine when a second
// result is ready. No clearing pass follows reset: link words are written
// together with each new node.
module bst_insert_traverse_engine_core #(
    parameter int CAPACITY = bsti_pkg::CAPACITY_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [1:0]  s_tuser,   // [1:0] operation
    // Result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] value_res
    output logic [1:0]  m_tuser,   // [1:0] result_kind
    output logic        m_tlast
);

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int NODE_W = bsti_pkg::VALUE_W + 2 * IDX_W;
    localparam int ENT_W  = IDX_W + 1;

    logic              node_we;
    logic [IDX_W-1:0]  node_waddr;
    logic [NODE_W-1:0] node_wdata;
    logic [IDX_W-1:0]  node_raddr;
    logic [NODE_W-1:0] node_rdata;
    logic              stk_we;
    logic [IDX_W-1:0]  stk_waddr;
    logic [ENT_W-1:0]  stk_wdata;
    logic [IDX_W-1:0]  stk_raddr;
    logic [ENT_W-1:0]  stk_rdata;

    logic              res_valid;
    logic              res_ready;
    bsti_pkg::result_t res;
    bsti_pkg::result_t m_res;

    // Node store
    bsti_ram #(
        .WIDTH (NODE_W),
        .DEPTH (CAPACITY)
    ) u_node_ram (
        .aclk  (aclk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    // Walk stack
    bsti_ram #(
        .WIDTH (ENT_W),
        .DEPTH (CAPACITY)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // Sequencer
    bsti_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (s_tuser),
        .in_value   (s_tdata),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .node_we    (node_we),
        .node_waddr (node_waddr),
        .node_wdata (node_wdata),
        .node_raddr (node_raddr),
        .node_rdata (node_rdata),
        .stk_we     (stk_we),
        .stk_waddr  (stk_waddr),
        .stk_wdata  (stk_wdata),
        .stk_raddr  (stk_raddr),
        .stk_rdata  (stk_rdata)
    );

    // Result register
    bsti_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_res     (m_res)
    );

    assign m_tdata = m_res.value;
    assign m_tuser = m_res.kind;
    assign m_tlast = m_res.last;

endmodule

// ----- design/bsti_ram.sv -----
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps

module bsti_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry, read one entry a cycle
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/bsti_out_stage.sv -----
// Output register stage that holds one result transaction for the master side.
`timescale 1ns / 1ps

module bsti_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              res_valid,
    output logic              res_ready,
    input  bsti_pkg::result_t res,
    output logic              m_valid,
    input  logic              m_ready,
    output bsti_pkg::result_t m_res
);

    logic              valid_reg;
    logic              valid_next;
    bsti_pkg::result_t data_reg;

    // Take a new result whenever the slot is empty or drains this cycle
    assign res_ready  = !valid_reg || m_ready;
    assign valid_next = (res_valid && res_ready) ? 1'b1 :
                        (m_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (res_valid && res_ready) begin
            data_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = data_reg;

endmodule

// ----- design/bsti_ctrl.sv -----
// Sequencer for tree inserts and stack-driven walks over the node and stack memories.
`timescale 1ns / 1ps

module bsti_ctrl #(
    parameter int CAPACITY = bsti_pkg::CAPACITY_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Request side
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [bsti_pkg::OP_W-1:0]          in_op,
    input  logic [bsti_pkg::VALUE_W-1:0]       in_value,
    // Result side
    output logic                               res_valid,
    input  logic                               res_ready,
    output bsti_pkg::result_t                  res,
    // Node memory: {value, left, right}
    output logic                               node_we,
    output logic [$clog2(CAPACITY)-1:0]        node_waddr,
    output logic [bsti_pkg::VALUE_W+2*$clog2(CAPACITY)-1:0] node_wdata,
    output logic [$clog2(CAPACITY)-1:0]        node_raddr,
    input  logic [bsti_pkg::VALUE_W+2*$clog2(CAPACITY)-1:0] node_rdata,
    // Walk stack memory: {emit flag, node index}
    output logic                               stk_we,
    output logic [$clog2(CAPACITY)-1:0]        stk_waddr,
    output logic [$clog2(CAPACITY):0]          stk_wdata,
    output logic [$clog2(CAPACITY)-1:0]        stk_raddr,
    input  logic [$clog2(CAPACITY):0]          stk_rdata
);

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int VAL_W  = bsti_pkg::VALUE_W;
    localparam int NODE_W = VAL_W + 2 * IDX_W;
    localparam int ENT_W  = IDX_W + 1;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam logic [IDX_W-1:0] LINK_NONE = '0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ICMP,
        S_WNEW,
        S_WND,
        S_PUSH,
        S_EMIT,
        S_POP,
        S_PWT
    } state_t;

    state_t                     state_reg, state_next;
    logic [bsti_pkg::OP_W-1:0]  op_reg, op_next;
    logic [VAL_W-1:0]           key_reg, key_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [IDX_W-1:0]           cur_idx_reg, cur_idx_next;
    logic                       cur_flag_reg, cur_flag_next;
    logic [CNT_W-1:0]           sp_reg, sp_next;
    logic [CNT_W-1:0]           emit_cnt_reg, emit_cnt_next;
    logic [ENT_W-1:0]           push0_reg, push0_next;
    logic [ENT_W-1:0]           push1_reg, push1_next;
    logic                       push0_vld_reg, push0_vld_next;
    logic                       push1_vld_reg, push1_vld_next;
    logic                       walk_reg, walk_next;
    logic [bsti_pkg::KIND_W-1:0] pend_kind_reg, pend_kind_next;
    logic [VAL_W-1:0]           pend_val_reg, pend_val_next;
    logic                       pend_last_reg, pend_last_next;

    // Fields of the node just read
    logic [VAL_W-1:0] rd_val;
    logic [IDX_W-1:0] rd_left;
    logic [IDX_W-1:0] rd_right;
    logic             go_left;
    logic [IDX_W-1:0] link;
    logic [IDX_W-1:0] new_idx;
    logic             last_elem;

    // Expansion of one node into ordered stack entries
    logic [ENT_W-1:0] ent0, ent1, ent2;
    logic             pres0, pres1, pres2;
    logic [ENT_W-1:0] carry_ent;
    logic [ENT_W-1:0] exp_push0, exp_push1;
    logic             exp_vld0, exp_vld1;

    assign rd_val    = node_rdata[NODE_W-1 -: VAL_W];
    assign rd_left   = node_rdata[2*IDX_W-1 -: IDX_W];
    assign rd_right  = node_rdata[IDX_W-1:0];
    assign go_left   = $signed(key_reg) <= $signed(rd_val);
    assign link      = go_left ? rd_left : rd_right;
    assign new_idx   = count_reg[IDX_W-1:0];
    assign last_elem = (emit_cnt_reg == CNT_W'(count_reg - 1'b1));

    // Order the children and the deferred emit of this node by walk kind
    always_comb begin
        case (op_reg)
            bsti_pkg::OP_PRE: begin
                ent0 = {1'b0, rd_right};         pres0 = (rd_right != LINK_NONE);
                ent1 = {1'b0, rd_left};          pres1 = (rd_left != LINK_NONE);
                ent2 = {1'b1, cur_idx_reg};      pres2 = 1'b1;
            end
            bsti_pkg::OP_IN: begin
                ent0 = {1'b0, rd_right};         pres0 = (rd_right != LINK_NONE);
                ent1 = {1'b1, cur_idx_reg};      pres1 = 1'b1;
                ent2 = {1'b0, rd_left};          pres2 = (rd_left != LINK_NONE);
            end
            default: begin
                ent0 = {1'b1, cur_idx_reg};      pres0 = 1'b1;
                ent1 = {1'b0, rd_right};         pres1 = (rd_right != LINK_NONE);
                ent2 = {1'b0, rd_left};          pres2 = (rd_left != LINK_NONE);
            end
        endcase
    end

    // Keep the last present entry as the next one to process, push the rest
    always_comb begin
        carry_ent = ent0;
        exp_push0 = ent0;
        exp_push1 = ent1;
        exp_vld0  = 1'b0;
        exp_vld1  = 1'b0;
        if (pres2) begin
            carry_ent = ent2;
            if (pres0) begin
                exp_push0 = ent0;
                exp_vld0  = 1'b1;
                exp_push1 = ent1;
                exp_vld1  = pres1;
            end else begin
                exp_push0 = ent1;
                exp_vld0  = pres1;
            end
        end else if (pres1) begin
            carry_ent = ent1;
            exp_push0 = ent0;
            exp_vld0  = pres0;
        end
    end

    // Next-state and memory access logic
    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        count_next     = count_reg;
        cur_idx_next   = cur_idx_reg;
        cur_flag_next  = cur_flag_reg;
        sp_next        = sp_reg;
        emit_cnt_next  = emit_cnt_reg;
        push0_next     = push0_reg;
        push1_next     = push1_reg;
        push0_vld_next = push0_vld_reg;
        push1_vld_next = push1_vld_reg;
        walk_next      = walk_reg;
        pend_kind_next = pend_kind_reg;
        pend_val_next  = pend_val_reg;
        pend_last_next = pend_last_reg;

        in_ready   = 1'b0;
        res_valid  = 1'b0;
        node_we    = 1'b0;
        node_waddr = cur_idx_reg;
        node_wdata = {key_reg, LINK_NONE, LINK_NONE};
        node_raddr = cur_idx_reg;
        stk_we     = 1'b0;
        stk_waddr  = sp_reg[IDX_W-1:0];
        stk_wdata  = push0_reg;
        stk_raddr  = IDX_W'(sp_reg - 1'b1);

        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    op_next  = in_op;
                    key_next = in_value;
                    case (in_op)
                        bsti_pkg::OP_INSERT: begin
                            walk_next = 1'b0;
                            if (count_reg == CAP_CNT) begin
                                pend_kind_next = bsti_pkg::KIND_FULL;
                                pend_val_next  = in_value;
                                pend_last_next = 1'b1;
                                state_next     = S_EMIT;
                            end else if (count_reg == '0) begin
                                state_next = S_WNEW;
                            end else begin
                                node_raddr   = LINK_NONE;
                                cur_idx_next = LINK_NONE;
                                state_next   = S_ICMP;
                            end
                        end
                        default: begin
                            if (count_reg == '0) begin
                                walk_next      = 1'b0;
                                pend_kind_next = bsti_pkg::KIND_EMPTY;
                                pend_val_next  = '0;
                                pend_last_next = 1'b1;
                                state_next     = S_EMIT;
                            end else begin
                                walk_next      = 1'b1;
                                node_raddr     = LINK_NONE;
                                cur_idx_next   = LINK_NONE;
                                cur_flag_next  = 1'b0;
                                sp_next        = '0;
                                emit_cnt_next  = '0;
                                push0_vld_next = 1'b0;
                                push1_vld_next = 1'b0;
                                state_next     = S_WND;
                            end
                        end
                    endcase
                end
            end

            // Descend one level per cycle; attach at the first empty link
            S_ICMP: begin
                if (link != LINK_NONE) begin
                    node_raddr   = link;
                    cur_idx_next = link;
                end else begin
                    node_we    = 1'b1;
                    node_waddr = cur_idx_reg;
                    node_wdata = {rd_val,
                                  go_left ? new_idx : rd_left,
                                  go_left ? rd_right : new_idx};
                    state_next = S_WNEW;
                end
            end

            // Write the new node with empty links
            S_WNEW: begin
                node_we        = 1'b1;
                node_waddr     = new_idx;
                node_wdata     = {key_reg, LINK_NONE, LINK_NONE};
                count_next     = CNT_W'(count_reg + 1'b1);
                pend_kind_next = bsti_pkg::KIND_INSERTED;
                pend_val_next  = key_reg;
                pend_last_next = 1'b1;
                state_next     = S_EMIT;
            end

            // Node data is back: emit it or expand it
            S_WND: begin
                if (cur_flag_reg) begin
                    pend_kind_next = bsti_pkg::KIND_ELEMENT;
                    pend_val_next  = rd_val;
                    pend_last_next = last_elem;
                    state_next     = S_EMIT;
                end else begin
                    cur_idx_next   = carry_ent[IDX_W-1:0];
                    cur_flag_next  = carry_ent[IDX_W];
                    push0_next     = exp_push0;
                    push1_next     = exp_push1;
                    push0_vld_next = exp_vld0;
                    push1_vld_next = exp_vld1;
                    pend_val_next  = rd_val;
                    state_next     = S_PUSH;
                end
            end

            // Push pending entries, then go on with the carried entry
            S_PUSH: begin
                if (push0_vld_reg) begin
                    stk_we         = 1'b1;
                    stk_waddr      = sp_reg[IDX_W-1:0];
                    stk_wdata      = push0_reg;
                    sp_next        = CNT_W'(sp_reg + 1'b1);
                    push0_next     = push1_reg;
                    push0_vld_next = push1_vld_reg;
                    push1_vld_next = 1'b0;
                end else if (cur_flag_reg) begin
                    pend_kind_next = bsti_pkg::KIND_ELEMENT;
                    pend_last_next = last_elem;
                    state_next     = S_EMIT;
                end else begin
                    node_raddr = cur_idx_reg;
                    state_next = S_WND;
                end
            end

            // Hand the result to the output stage
            S_EMIT: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    if (walk_reg) begin
                        emit_cnt_next = CNT_W'(emit_cnt_reg + 1'b1);
                        state_next    = pend_last_reg ? S_IDLE : S_POP;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end

            // Pop the top of the stack
            S_POP: begin
                stk_raddr  = IDX_W'(sp_reg - 1'b1);
                sp_next    = CNT_W'(sp_reg - 1'b1);
                state_next = S_PWT;
            end

            // Popped entry is back: fetch its node
            S_PWT: begin
                cur_idx_next  = stk_rdata[IDX_W-1:0];
                cur_flag_next = stk_rdata[IDX_W];
                node_raddr    = stk_rdata[IDX_W-1:0];
                state_next    = S_WND;
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res.kind  = pend_kind_reg;
    assign res.value = pend_val_reg;
    assign res.last  = pend_last_reg;

    // Hold state and registered values
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            sp_reg        <= '0;
            emit_cnt_reg  <= '0;
            push0_vld_reg <= 1'b0;
            push1_vld_reg <= 1'b0;
            walk_reg      <= 1'b0;
            cur_flag_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sp_reg        <= sp_next;
            emit_cnt_reg  <= emit_cnt_next;
            push0_vld_reg <= push0_vld_next;
            push1_vld_reg <= push1_vld_next;
            walk_reg      <= walk_next;
            cur_flag_reg  <= cur_flag_next;
        end
        op_reg        <= op_next;
        key_reg       <= key_next;
        cur_idx_reg   <= cur_idx_next;
        push0_reg     <= push0_next;
        push1_reg     <= push1_next;
        pend_kind_reg <= pend_kind_next;
        pend_val_reg  <= pend_val_next;
        pend_last_reg <= pend_last_next;
    end

    // The node count never passes the store size
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_CNT)
        else $error("node count beyond capacity");

    // A push always finds room on the stack
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PUSH && push0_vld_reg) |-> sp_reg < CAP_CNT)
        else $error("stack overflow");

    // A pop always finds an entry
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_POP) |-> sp_reg != '0)
        else $error("stack underflow");

    // A walk never emits more elements than stored keys
    a_emit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT && walk_reg) |-> emit_cnt_reg < count_reg)
        else $error("walk emitted too many elements");

    // The count only grows by one, and only after a new node write
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && count_reg != $past(count_reg)) |->
            ($past(state_reg) == S_WNEW && count_reg == CNT_W'($past(count_reg) + 1'b1)))
        else $error("unexpected node count change");

endmodule
